FILE: src/cmpgc_pkg.sv
`default_nettype none
package cmpgc_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [2:0] CFG_RATIO        = 3'd1;
    localparam logic [2:0] CFG_KNEE         = 3'd2;
    localparam logic [2:0] CFG_MODE         = 3'd3;
    localparam logic [2:0] CFG_ATTACK       = 3'd4;
    localparam logic [2:0] CFG_RELEASE      = 3'd5;
    localparam logic [2:0] CFG_SLOW_ATTACK  = 3'd6;
    localparam logic [2:0] CFG_SLOW_RELEASE = 3'd7;

    // Reset values of the registers (threshold is -20 dB in Q8.8).
    localparam logic [14:0] THRESHOLD_RST    = 15'h6C00;
    localparam logic [11:0] RATIO_RST        = 12'd512;
    localparam logic [12:0] KNEE_RST         = 13'd2560;
    localparam logic [3:0]  MODE_RST         = 4'd0;
    localparam logic [15:0] ATTACK_RST       = 16'd64000;
    localparam logic [15:0] RELEASE_RST      = 16'd65500;
    localparam logic [15:0] SLOW_ATTACK_RST  = 16'd65400;
    localparam logic [15:0] SLOW_RELEASE_RST = 16'd65520;

    // Fixed release pole of the fast residual in dual release.
    localparam logic [15:0] FAST_RELEASE_Q16 = 16'd65509;

    // Reciprocals for the constant divisions by 5 (shift 18) and by 100 (shift 26).
    localparam logic [15:0] RECIP5   = 16'd52429;
    localparam logic [19:0] RECIP100 = 20'd671089;

    typedef struct packed {
        logic [14:0] threshold_db;
        logic [11:0] ratio_q8;
        logic [12:0] knee_db;
        logic [3:0]  mode_select;
        logic [15:0] attack_coeff;
        logic [15:0] release_coeff;
        logic [15:0] slow_attack_coeff;
        logic [15:0] slow_release_coeff;
    } cfg_t;

    // One target gain handed from the front to the back.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] tgt;
    } push_t;

    typedef enum logic [1:0] {
        GM_NORMAL,
        GM_SOFT,
        GM_HARD
    } gain_mode_t;

    typedef enum logic [1:0] {
        SM_DUAL,
        SM_SINGLE,
        SM_OPTO
    } smooth_mode_t;

    function automatic gain_mode_t gain_mode(input logic [3:0] m);
        gain_mode_t g;
        unique case (m)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: g = GM_NORMAL;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       g = GM_SOFT;
            default:                              g = GM_HARD;
        endcase
        return g;
    endfunction

    function automatic smooth_mode_t smooth_mode(input logic [3:0] m);
        smooth_mode_t s;
        unique case (m)
            4'd3, 4'd4, 4'd5: s = SM_SINGLE;
            4'd6, 4'd7, 4'd8: s = SM_OPTO;
            default:          s = SM_DUAL;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: src/cmpgc_div.sv
`default_nettype none
module cmpgc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [29:0] dividend,
    input  logic [13:0] divisor,
    output logic        busy,
    output logic [29:0] quotient
);
    import cmpgc_pkg::*;

    // Restoring division, two quotient bits a cycle.
    logic [29:0] dvd_reg, dvd_next;
    logic [29:0] quo_reg, quo_next;
    logic [13:0] rem_reg, rem_next;
    logic [13:0] dsr_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    always_comb
    begin
        logic [14:0] t;
        logic [29:0] d;
        logic [29:0] q;
        logic [13:0] r;
        d = dvd_reg;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            t = {r, d[29]};
            d = {d[28:0], 1'b0};
            if (t >= {1'b0, dsr_reg})
            begin
                t = t - {1'b0, dsr_reg};
                q = {q[28:0], 1'b1};
            end
            else
            begin
                q = {q[28:0], 1'b0};
            end
            r = t[13:0];
        end
        dvd_next  = d;
        quo_next  = q;
        rem_next  = r;
        cnt_next  = cnt_reg + 4'd1;
        busy_next = (cnt_reg != 4'd14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd0;
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= 30'd0;
            rem_reg <= 14'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: src/cmpgc_front.sv
`default_nettype none
module cmpgc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  cmpgc_pkg::cfg_t    cfg,
    input  logic signed [16:0] level_db,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               q_full,
    output cmpgc_pkg::push_t   push
);
    import cmpgc_pkg::*;

    typedef enum logic [9:0] {
        F_IDLE  = 10'b0000000001,
        F_PREP  = 10'b0000000010,
        F_RLOAD = 10'b0000000100,
        F_RWAIT = 10'b0000001000,
        F_CLASS = 10'b0000010000,
        F_SQ    = 10'b0000100000,
        F_NUM   = 10'b0001000000,
        F_KLOAD = 10'b0010000000,
        F_KWAIT = 10'b0100000000,
        F_PUSH  = 10'b1000000000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic signed [16:0] level_reg;
    logic signed [17:0] over_reg;
    logic [12:0]        r_reg;
    logic [13:0]        k_reg;
    logic [16:0]        s_reg;
    logic [14:0]        t2_reg;
    logic [29:0]        sq_reg;
    logic [29:0]        kdvd_reg;
    logic [17:0]        mag_reg;

    logic        div_start;
    logic [29:0] div_dvd;
    logic [13:0] div_dsr;
    logic        div_busy;
    logic [29:0] div_q;

    cmpgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Effective ratio and knee for the selected gain mode.
    logic [11:0]        r_base, d;
    logic [13:0]        d3;
    logic [29:0]        soft_prod;
    logic [18:0]        knee33;
    logic [38:0]        hard_k_prod;
    logic [12:0]        r_eff;
    logic [13:0]        k_eff;
    logic signed [17:0] over;

    always_comb
    begin
        r_base      = (cfg.ratio_q8 < 12'd256) ? 12'd256 : cfg.ratio_q8;
        d           = r_base - 12'd256;
        d3          = 14'({2'b00, d} * 14'd3);
        soft_prod   = 30'(d3 + 14'd2) * 30'(RECIP5);
        knee33      = 19'(cfg.knee_db) * 19'd33 + 19'd50;
        hard_k_prod = 39'(knee33) * 39'(RECIP100);
        unique case (gain_mode(cfg.mode_select))
            GM_SOFT:
            begin
                r_eff = 13'd256 + 13'(soft_prod[29:18]);
                k_eff = 14'(cfg.knee_db) + 14'd1536;
            end
            GM_HARD:
            begin
                r_eff = 13'd256 + 13'((d3 + 14'd1) >> 1);
                k_eff = 14'(hard_k_prod[38:26]);
            end
            default:
            begin
                r_eff = 13'(r_base);
                k_eff = 14'(cfg.knee_db);
            end
        endcase
        over = $signed({level_reg[16], level_reg})
             - $signed({{3{cfg.threshold_db[14]}}, cfg.threshold_db});
    end

    // Curve region and the products that feed it.
    logic signed [18:0] over2, k19;
    logic               above, in_knee;
    logic [16:0]        s;
    logic [33:0]        lin_prod;
    logic [46:0]        num;

    always_comb
    begin
        over2    = {over_reg, 1'b0};
        k19      = $signed({5'b0, k_reg});
        above    = over2 > k19;
        in_knee  = (k_reg != 14'd0) && (over2 > -k19);
        s        = 17'h10000 - div_q[16:0];
        lin_prod = 34'(over_reg[16:0]) * 34'(s);
        num      = 47'(s_reg) * 47'(sq_reg);
    end

    logic [17:0] mag_sat;

    always_comb
    begin
        mag_sat   = (mag_reg > 18'd32768) ? 18'd32768 : mag_reg;
        push.tgt  = 16'(18'd0 - mag_sat);
        push.valid = (state_reg == F_PUSH) && !q_full;
        in_stall  = (state_reg != F_IDLE);
        div_start = (state_reg == F_RLOAD) || (state_reg == F_KLOAD);
        div_dvd   = (state_reg == F_RLOAD) ? (30'h1000000 + 30'(r_reg >> 1)) : kdvd_reg;
        div_dsr   = (state_reg == F_RLOAD) ? 14'(r_reg) : k_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (in_valid) state_next = F_PREP;
            F_PREP:  state_next = F_RLOAD;
            F_RLOAD: state_next = F_RWAIT;
            F_RWAIT: if (!div_busy) state_next = F_CLASS;
            F_CLASS:
            begin
                priority if (above)   state_next = F_PUSH;
                else if (in_knee)     state_next = F_SQ;
                else                  state_next = F_PUSH;
            end
            F_SQ:    state_next = F_NUM;
            F_NUM:   state_next = F_KLOAD;
            F_KLOAD: state_next = F_KWAIT;
            F_KWAIT: if (!div_busy) state_next = F_PUSH;
            F_PUSH:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            level_reg <= level_db;
        end
        if (state_reg == F_PREP)
        begin
            r_reg    <= r_eff;
            k_reg    <= k_eff;
            over_reg <= over;
        end
        if (state_reg == F_RWAIT)
        begin
            mag_reg <= 18'd0;
        end
        if (state_reg == F_CLASS)
        begin
            s_reg  <= s;
            t2_reg <= 15'(over2 + k19);
            if (above)
            begin
                mag_reg <= 18'((lin_prod + 34'd32768) >> 16);
            end
        end
        if (state_reg == F_SQ)
        begin
            sq_reg <= 30'(t2_reg) * 30'(t2_reg);
        end
        if (state_reg == F_NUM)
        begin
            kdvd_reg <= 30'((num + (47'(k_reg) << 18)) >> 19);
        end
        if (state_reg == F_KWAIT && !div_busy)
        begin
            mag_reg <= 18'(div_q);
        end
    end

endmodule
`default_nettype wire

FILE: src/cmpgc_queue.sv
`default_nettype none
module cmpgc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  cmpgc_pkg::push_t   push,
    output logic               full,
    input  logic               pop,
    output logic               has_data,
    output logic signed [15:0] head
);
    import cmpgc_pkg::*;

    logic signed [15:0] mem_reg [2];
    logic               wr_reg, rd_reg;
    logic [1:0]         cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push.valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_reg] <= push.tgt;
        end
    end

    assign full     = (cnt_reg == 2'd2);
    assign has_data = (cnt_reg != 2'd0);
    assign head     = mem_reg[rd_reg];

endmodule
`default_nettype wire

FILE: src/cmpgc_back.sv
`default_nettype none
module cmpgc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cmpgc_pkg::cfg_t    cfg,
    input  logic               has_data,
    input  logic signed [15:0] head,
    output logic               pop,
    output logic signed [15:0] target_gain_db,
    output logic signed [15:0] applied_gain_db,
    output logic               out_valid,
    input  logic               out_stall
);
    import cmpgc_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL1 = 6'b000010,
        B_ADD1 = 6'b000100,
        B_MUL2 = 6'b001000,
        B_ADD2 = 6'b010000,
        B_HOLD = 6'b100000
    } bstate_t;

    // round(diff * c / 2^16) with ties away from zero.
    function automatic logic signed [25:0] mul_round16(input logic signed [25:0] diff,
                                                        input logic [16:0] c);
        logic [25:0] mag;
        logic [42:0] prod;
        logic [25:0] q;
        mag  = diff[25] ? 26'(-diff) : 26'(diff);
        prod = 43'(mag) * 43'(c);
        q    = 26'((prod + 43'd32768) >> 16);
        return diff[25] ? $signed(26'(26'd0 - q)) : $signed(q);
    endfunction

    bstate_t            state_reg, state_next;
    logic signed [23:0] single_acc_reg, slow_acc_reg, fast_acc_reg, opto_acc_reg;
    logic signed [15:0] tgt_reg;
    logic signed [25:0] prod_reg;
    logic signed [23:0] resid_reg;
    logic [15:0]        rel_reg;
    logic signed [15:0] tgt_out_reg, app_out_reg, app_res_reg;
    logic               out_valid_reg;

    smooth_mode_t       sm;
    logic signed [23:0] x;
    logic signed [25:0] x26;
    logic signed [25:0] diff;
    logic [16:0]        c;
    logic [16:0]        depth;
    logic [24:0]        neg_opto;
    logic [21:0]        depth_raw;
    logic signed [25:0] sum;
    logic signed [23:0] acc_new;
    logic signed [24:0] resid_full;
    logic signed [24:0] applied;
    logic [24:0]        app_mag;
    logic [16:0]        app_q;
    logic [16:0]        app_sat;
    logic               out_free;

    function automatic logic signed [25:0] ext26(input logic signed [23:0] v);
        return {{2{v[23]}}, v};
    endfunction

    always_comb
    begin
        sm  = smooth_mode(cfg.mode_select);
        x   = {tgt_reg, 8'h00};
        x26 = ext26(x);

        // Opto pole slides toward the slow release as the reduction deepens to 8 dB.
        neg_opto  = 25'(0) - 25'({opto_acc_reg[23], opto_acc_reg});
        depth_raw = neg_opto[24:3];
        if (!opto_acc_reg[23])
        begin
            depth = 17'd0;
        end
        else if (depth_raw > 22'd65536)
        begin
            depth = 17'h10000;
        end
        else
        begin
            depth = 17'(depth_raw);
        end

        diff = 26'sd0;
        c    = 17'd0;
        if (state_reg == B_MUL1)
        begin
            unique case (sm)
                SM_SINGLE:
                begin
                    diff = ext26(single_acc_reg) - x26;
                    c    = {1'b0, (x < single_acc_reg) ? cfg.attack_coeff : cfg.release_coeff};
                end
                SM_OPTO:
                begin
                    diff = $signed({10'b0, cfg.slow_release_coeff})
                         - $signed({10'b0, cfg.release_coeff});
                    c    = depth;
                end
                default:
                begin
                    diff = ext26(slow_acc_reg) - x26;
                    c    = {1'b0, (x < slow_acc_reg) ? cfg.slow_attack_coeff
                                                     : cfg.slow_release_coeff};
                end
            endcase
        end
        else if (state_reg == B_MUL2)
        begin
            if (sm == SM_OPTO)
            begin
                diff = ext26(opto_acc_reg) - x26;
                c    = {1'b0, (x < opto_acc_reg) ? cfg.attack_coeff : rel_reg};
            end
            else
            begin
                diff = ext26(fast_acc_reg) - ext26(resid_reg);
                c    = {1'b0, (resid_reg < fast_acc_reg) ? cfg.attack_coeff
                                                         : FAST_RELEASE_Q16};
            end
        end

        // The pole output: x + rounded product (for the fast residual, resid).
        if (state_reg == B_ADD2 && sm != SM_OPTO)
        begin
            sum = ext26(resid_reg) + prod_reg;
        end
        else
        begin
            sum = x26 + prod_reg;
        end
        acc_new = sum[23:0];

        resid_full = 25'({x[23], x}) - 25'({acc_new[23], acc_new});
        if (state_reg == B_ADD2 && sm == SM_DUAL)
        begin
            applied = 25'({slow_acc_reg[23], slow_acc_reg}) + 25'({acc_new[23], acc_new});
        end
        else
        begin
            applied = {acc_new[23], acc_new};
        end
        app_mag = applied[24] ? 25'(25'd0 - applied) : 25'd0;
        app_q   = 17'((app_mag + 25'd128) >> 8);
        app_sat = (app_q > 17'd32768) ? 17'd32768 : app_q;

        out_free = !out_valid_reg || !out_stall;
        pop      = (state_reg == B_IDLE) && has_data;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (has_data) state_next = B_MUL1;
            B_MUL1: state_next = B_ADD1;
            B_ADD1: state_next = (sm == SM_SINGLE) ? B_HOLD : B_MUL2;
            B_MUL2: state_next = B_ADD2;
            B_ADD2: state_next = B_HOLD;
            B_HOLD: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            single_acc_reg <= 24'sd0;
            slow_acc_reg   <= 24'sd0;
            fast_acc_reg   <= 24'sd0;
            opto_acc_reg   <= 24'sd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_ADD1)
            begin
                unique case (sm)
                    SM_SINGLE: single_acc_reg <= acc_new;
                    SM_OPTO:   ;
                    default:   slow_acc_reg   <= acc_new;
                endcase
            end
            if (state_reg == B_ADD2)
            begin
                if (sm == SM_OPTO)
                begin
                    opto_acc_reg <= acc_new;
                end
                else
                begin
                    fast_acc_reg <= acc_new;
                end
            end
            if (state_reg == B_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tgt_reg <= head;
        end
        if (state_reg == B_MUL1 || state_reg == B_MUL2)
        begin
            prod_reg <= mul_round16(diff, c);
        end
        if (state_reg == B_ADD1)
        begin
            // In opto mode the first product moves the release pole off release_coeff.
            rel_reg     <= 16'($signed({10'b0, cfg.release_coeff}) + prod_reg);
            resid_reg   <= resid_full[24] ? resid_full[23:0] : 24'sd0;
            app_res_reg <= 16'(17'd0 - app_sat);
        end
        if (state_reg == B_ADD2)
        begin
            app_res_reg <= 16'(17'd0 - app_sat);
        end
        if (state_reg == B_HOLD && out_free)
        begin
            tgt_out_reg <= tgt_reg;
            app_out_reg <= app_res_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign target_gain_db  = tgt_out_reg;
    assign applied_gain_db = app_out_reg;

endmodule
`default_nettype wire

FILE: src/compressor_gain_computer_smoother.sv
// Gain computer and gain smoother of a downward dynamics compressor.
// The input channel (level_db, in_valid, in_stall) carries one detected level
// word per audio sample; a word is taken at a clock edge with in_valid high and
// in_stall low. The output channel (target_gain_db, applied_gain_db, out_valid,
// out_stall) returns one word per input word, in order.
// The front computes the static soft-knee curve. Its shared radix-4 divider
// forms the slope reciprocal and, inside the knee, the knee quotient; the front
// takes no new word until it has pushed its gain to the queue, and that divider
// sets the throughput. A two-word queue feeds the back, which runs the selected
// ballistics through one shared pole multiplier in the steps B_MUL1 and B_ADD1
// (and, except in single mode, B_MUL2 and B_ADD2) and holds the result in an
// output register. A stalled output holds its word; the back then waits, and
// the queue and the front keep taking words until the queue is full and the
// front holds a word, after which in_stall stays high.
// Reset clears all four gain accumulators to 0 dB and loads the register
// defaults. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
`default_nettype none
module compressor_gain_computer_smoother (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [16:0] level_db,
    input  logic               in_valid,
    output logic               in_stall,
    output logic signed [15:0] target_gain_db,
    output logic signed [15:0] applied_gain_db,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import cmpgc_pkg::*;

    cfg_t               cfg_reg;
    push_t              push;
    logic               q_full;
    logic               q_has_data;
    logic               q_pop;
    logic signed [15:0] q_head;

    // Configuration registers; every index in the port's range names a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db       <= THRESHOLD_RST;
            cfg_reg.ratio_q8           <= RATIO_RST;
            cfg_reg.knee_db            <= KNEE_RST;
            cfg_reg.mode_select        <= MODE_RST;
            cfg_reg.attack_coeff       <= ATTACK_RST;
            cfg_reg.release_coeff      <= RELEASE_RST;
            cfg_reg.slow_attack_coeff  <= SLOW_ATTACK_RST;
            cfg_reg.slow_release_coeff <= SLOW_RELEASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:    cfg_reg.threshold_db       <= cfg_data[14:0];
                CFG_RATIO:        cfg_reg.ratio_q8           <= cfg_data[11:0];
                CFG_KNEE:         cfg_reg.knee_db            <= cfg_data[12:0];
                CFG_MODE:         cfg_reg.mode_select        <= cfg_data[3:0];
                CFG_ATTACK:       cfg_reg.attack_coeff       <= cfg_data;
                CFG_RELEASE:      cfg_reg.release_coeff      <= cfg_data;
                CFG_SLOW_ATTACK:  cfg_reg.slow_attack_coeff  <= cfg_data;
                CFG_SLOW_RELEASE: cfg_reg.slow_release_coeff <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Front: takes the level word and works out the static curve gain.
    cmpgc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .level_db (level_db),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_full   (q_full),
        .push     (push)
    );

    // Short queue of target gains between the curve and the ballistics.
    cmpgc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (q_full),
        .pop      (q_pop),
        .has_data (q_has_data),
        .head     (q_head)
    );

    // Back: smooths the gain and owns the output register.
    cmpgc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .has_data        (q_has_data),
        .head            (q_head),
        .pop             (q_pop),
        .target_gain_db  (target_gain_db),
        .applied_gain_db (applied_gain_db),
        .out_valid       (out_valid),
        .out_stall       (out_stall)
    );

endmodule
`default_nettype wire

FILE: bench/compressor_gain_computer_smoother_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module compressor_gain_computer_smoother_tb;
    import cmpgc_pkg::*;

    // A result is one pair of gains, target first, then applied.
    typedef struct packed {
        logic signed [15:0] target;
        logic signed [15:0] applied;
    } gain_pair_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic signed [16:0] level_db = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] target_gain_db;
    logic signed [15:0] applied_gain_db;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    compressor_gain_computer_smoother uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .level_db        (level_db),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .target_gain_db  (target_gain_db),
        .applied_gain_db (applied_gain_db),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // The bench keeps its own copy of the registers and of the four gain
    // accumulators, the latter in Q8.16 dB, updated as each word is sent.
    logic [14:0] thr_reg;
    logic [11:0] ratio_reg;
    logic [12:0] knee_reg;
    logic [3:0]  mode_reg;
    logic [15:0] atk_reg, rel_reg, slow_atk_reg, slow_rel_reg;
    longint      single_acc, slow_acc, fast_acc, opto_acc;

    gain_pair_t  expected_gains[$];
    int          failures = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    longint      cycle_count = 0;

    // Rounded product with a Q0.16 pole, ties away from zero.
    function automatic longint scale_q16(input longint diff, input longint c);
        longint mag;
        mag = (diff < 0) ? -diff : diff;
        mag = (mag * c + 32768) >>> 16;
        return (diff < 0) ? -mag : mag;
    endfunction

    function automatic longint pole_step(input longint acc, input longint x,
                                         input longint c);
        return x + scale_q16(acc - x, c);
    endfunction

    // Static soft-knee curve for one level, in Q8.8 dB.
    function automatic longint curve_gain(input longint level);
        gain_mode_t gm;
        longint r, k, d, s, over, thr, mag, t2, den;
        gm  = gain_mode(mode_reg);
        r   = (ratio_reg < 256) ? 256 : ratio_reg;
        k   = knee_reg;
        d   = r - 256;
        thr = $signed(thr_reg);
        if (gm == GM_SOFT) begin
            r = 256 + (d * 3 + 2) / 5;
            k = knee_reg + 1536;
        end
        else if (gm == GM_HARD) begin
            r = 256 + (d * 3 + 1) / 2;
            k = (knee_reg * 33 + 50) / 100;
        end
        s    = 65536 - ((64'sd1 <<< 24) + r / 2) / r;
        over = level - thr;
        if (2 * over > k)
            mag = (over * s + 32768) >>> 16;
        else if (k > 0 && 2 * over > -k) begin
            t2  = 2 * over + k;
            den = k * 8 * 65536;
            mag = (s * t2 * t2 + den / 2) / den;
        end
        else
            mag = 0;
        if (mag > 32768)
            mag = 32768;
        return -mag;
    endfunction

    // Runs one level through the curve and the selected ballistics.
    function automatic gain_pair_t smooth_gain(input longint level);
        gain_pair_t   res;
        smooth_mode_t sm;
        longint tgt, x, applied, depth, rel, resid, m, q;
        sm  = smooth_mode(mode_reg);
        tgt = curve_gain(level);
        x   = tgt * 256;
        if (sm == SM_OPTO) begin
            // The release pole slides towards the slow one as reduction deepens.
            depth = (opto_acc > 0) ? 0 : ((-opto_acc) >>> 3);
            if (depth > 65536)
                depth = 65536;
            rel = rel_reg + scale_q16(longint'(slow_rel_reg) - rel_reg, depth);
            opto_acc = pole_step(opto_acc, x, (x < opto_acc) ? atk_reg : rel);
            applied = opto_acc;
        end
        else if (sm == SM_SINGLE) begin
            single_acc = pole_step(single_acc, x, (x < single_acc) ? atk_reg : rel_reg);
            applied = single_acc;
        end
        else begin
            slow_acc = pole_step(slow_acc, x, (x < slow_acc) ? slow_atk_reg : slow_rel_reg);
            resid = x - slow_acc;
            if (resid > 0)
                resid = 0;
            fast_acc = pole_step(fast_acc, resid,
                                 (resid < fast_acc) ? atk_reg : FAST_RELEASE_Q16);
            applied = slow_acc + fast_acc;
        end
        m = (applied < 0) ? -applied : 0;
        q = (m + 128) >>> 8;
        if (q > 32768)
            q = 32768;
        res.target  = tgt[15:0];
        res.applied = 16'(-q);
        return res;
    endfunction

    // One register write, followed by a quiet cycle on the write port.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_THRESHOLD:    thr_reg      = value[14:0];
            CFG_RATIO:        ratio_reg    = value[11:0];
            CFG_KNEE:         knee_reg     = value[12:0];
            CFG_MODE:         mode_reg     = value[3:0];
            CFG_ATTACK:       atk_reg      = value;
            CFG_RELEASE:      rel_reg      = value;
            CFG_SLOW_ATTACK:  slow_atk_reg = value;
            default:          slow_rel_reg = value;
        endcase
        @(posedge clk);
    endtask

    // Sends one level word; the expectation is queued at the accepting edge.
    // in_valid stays high after acceptance only until the next call drives a
    // new word or idles, or until drain lowers it.
    task automatic send_level(input logic signed [16:0] lvl);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        level_db <= lvl;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_gains.push_back(smooth_gain(lvl));
    endtask

    // Waits for every outstanding word, then lets the pipeline settle so
    // that a register write cannot land on a word still in flight.
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_gains.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [16:0] random_level;
        case ($urandom_range(3))
            0:       return 17'(-35840 + $urandom_range(41984));
            1:       return 17'($signed(thr_reg) + $signed($urandom_range(6000)) - 3000);
            2:       return $urandom_range(1) ? 17'sd6144 : -17'sd35840;
            default: return 17'($signed(thr_reg) + $signed($urandom_range(6144)));
        endcase
    endfunction

    // Extremes of the level and the curve regions under the reset settings.
    task automatic test_directed_levels;
        logic signed [16:0] lvls[12] = '{-17'sd35840, 17'sd6144, 17'sd0, -17'sd5120,
                                         -17'sd6400, -17'sd3840, -17'sd6399,
                                         -17'sd1, 17'sd6144, -17'sd35840, 17'sd1,
                                         -17'sd10000};
        foreach (lvls[i])
            send_level(lvls[i]);
        drain();
    endtask

    // Each gain and smoothing mode, the selector values past opto, a ratio
    // below one, a zero knee and register extremes.
    task automatic test_modes_and_corners;
        for (int m = 0; m < 16; m++) begin
            write_reg(CFG_MODE, 16'(m));
            send_level(17'sd6144);
            drain();
        end
        write_reg(CFG_RATIO, 16'd100);
        send_level(17'sd6144);
        drain();
        write_reg(CFG_RATIO, 16'd4095);
        write_reg(CFG_KNEE, 16'd0);
        write_reg(CFG_THRESHOLD, 16'd0);
        send_level(17'sd0);
        send_level(17'sd1);
        send_level(17'sd6144);
        drain();
        write_reg(CFG_THRESHOLD, 16'h4400);
        write_reg(CFG_KNEE, 16'd5120);
        send_level(-17'sd35840);
        drain();
    endtask

    task automatic randomise_registers(input bit extreme);
        write_reg(CFG_THRESHOLD, extreme ? ($urandom_range(1) ? 16'd0 : 16'h4400)
                                         : 16'(-$urandom_range(15360)));
        write_reg(CFG_RATIO, extreme ? ($urandom_range(1) ? 16'd4095 : 16'd0)
                                     : 16'($urandom_range(4095)));
        write_reg(CFG_KNEE, extreme ? ($urandom_range(1) ? 16'd5120 : 16'd0)
                                    : 16'($urandom_range(8191)));
        write_reg(CFG_MODE, 16'($urandom_range(15)));
        write_reg(CFG_ATTACK, extreme ? 16'($urandom_range(1) * 65535)
                                      : 16'($urandom_range(65535)));
        write_reg(CFG_RELEASE, extreme ? 16'($urandom_range(1) * 65535)
                                       : 16'($urandom_range(65535)));
        write_reg(CFG_SLOW_ATTACK, 16'($urandom_range(65535)));
        write_reg(CFG_SLOW_RELEASE, 16'($urandom_range(65535)));
        write_reg(CFG_SLOW_RELEASE, extreme ? 16'hFFFF : 16'($urandom_range(65535)));
    endtask

    // Random levels in phases, each with fresh settings and one idling profile.
    task automatic test_random_phases(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int ph = 0; ph < 10; ph++) begin
            randomise_registers(ph < 3);
            for (int n = 0; n < 60; n++)
                send_level(random_level());
            drain();
        end
    endtask

    // The receiver holds off while words keep coming, so the block fills and
    // stalls its input; then the sender waits for the backlog to clear.
    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b1;
        for (int n = 0; n < 20; n++)
            send_level(random_level());
        drain();
        for (int n = 0; n < 20; n++)
            send_level(random_level());
        drain();
    endtask

    // Receiver stall: random idling plus the long hold-off.
    always @(posedge clk) begin
        if (hold_off) begin
            out_stall <= 1'b1;
            repeat (400) @(posedge clk);
            hold_off  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk) begin
        gain_pair_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_gains.size() == 0) begin
                failures++;
                $display("%0t: unexpected word target=%0d applied=%0d", $time,
                         target_gain_db, applied_gain_db);
            end
            else begin
                want = expected_gains.pop_front();
                if (want.target !== target_gain_db) begin
                    failures++;
                    $display("%0t: target_gain_db expected %0d actual %0d", $time,
                             want.target, target_gain_db);
                end
                if (want.applied !== applied_gain_db) begin
                    failures++;
                    $display("%0t: applied_gain_db expected %0d actual %0d", $time,
                             want.applied, applied_gain_db);
                end
            end
        end
    end

    // Watchdog sized for the slowest run with generous margin.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        thr_reg      = THRESHOLD_RST;
        ratio_reg    = RATIO_RST;
        knee_reg     = KNEE_RST;
        mode_reg     = MODE_RST;
        atk_reg      = ATTACK_RST;
        rel_reg      = RELEASE_RST;
        slow_atk_reg = SLOW_ATTACK_RST;
        slow_rel_reg = SLOW_RELEASE_RST;
        single_acc = 0;
        slow_acc   = 0;
        fast_acc   = 0;
        opto_acc   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_levels();
        test_modes_and_corners();
        test_random_phases(34, 60);
        test_random_phases(60, 34);
        test_random_phases(0, 0);
        test_backpressure();

        if (expected_gains.size() != 0)
            failures++;
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
